### rtl/core/lmfe_pkg.sv
// shared types, codes and font table of the led matrix framebuffer engine
package lmfe_pkg;

   typedef enum logic [3:0] {
      ACT_SET_PIXEL   = 4'd0,
      ACT_CLEAR_PIXEL = 4'd1,
      ACT_READ_PIXEL  = 4'd2,
      ACT_SET_COLUMN  = 4'd3,
      ACT_CLEAR       = 4'd4,
      ACT_FILL        = 4'd5,
      ACT_BAR         = 4'd6,
      ACT_CHAR        = 4'd7,
      ACT_FLUSH       = 4'd8
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_DONE  = 5'b00100,
      ST_HEAD  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   // latched command seen by the column unit
   typedef struct packed {
      action_type  action;
      logic [7:0]  x_pos;
      logic [7:0]  y_pos;
      logic [7:0]  column_data;
      logic [14:0] bar_max;
      logic [5:0]  glyph;
   } cmd_type;

   // per-step result of the column unit
   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_data;
      logic       pix;
      logic       last_step;
   } unit_ctl_type;

   localparam logic [15:0] HEADER_WORD = 16'd640;
   localparam logic [4:0]  HEADER_BITS = 5'd10;
   localparam logic [4:0]  COLUMN_BITS = 5'd16;
   localparam logic [7:0]  FONT_LO     = 8'd32;
   localparam logic [7:0]  FONT_HI     = 8'd90;
   localparam logic [7:0]  BYTE_ONES   = 8'hFF;
   localparam logic [7:0]  BYTE_ZEROS  = 8'h00;
   localparam logic [7:0]  CHAR_ADVANCE = 8'd6;
   localparam int          GLYPHS      = 59;

   // five columns per glyph, leftmost column in the top byte
   localparam logic [39:0] FONT_ROM [GLYPHS] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700,
      40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001C224100,
      40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h3E415D551E,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
      40'h0708700807, 40'h6151494543
   };

   function automatic logic [7:0] font_column(input logic [5:0] glyph, input logic [2:0] col);
      logic [39:0] row;
      logic [7:0]  byte_out;
      row = (glyph < 6'(GLYPHS)) ? FONT_ROM[glyph] : 40'h0;
      unique case (col)
         3'd0:    byte_out = row[39:32];
         3'd1:    byte_out = row[31:24];
         3'd2:    byte_out = row[23:16];
         3'd3:    byte_out = row[15:8];
         3'd4:    byte_out = row[7:0];
         default: byte_out = 8'h00;
      endcase
      return byte_out;
   endfunction

endpackage

### rtl/core/lmfe_col_unit.sv
// shared column unit: address generation, pixel masks, glyph lookup and bar compare
module lmfe_col_unit #(
   parameter int COLUMNS = 24
) (
   input  lmfe_pkg::cmd_type              cmd,
   input  logic [((COLUMNS > 8) ? $clog2(COLUMNS) : 3)-1:0] step,
   input  logic [7:0]                     rd_data,
   input  logic [15+$clog2(COLUMNS+1)-1:0] acc,
   input  logic [15+$clog2(COLUMNS+1)-1:0] target,
   output logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] idx,
   output logic [15+$clog2(COLUMNS+1)-1:0] acc_next,
   output lmfe_pkg::unit_ctl_type         ctl
);
   import lmfe_pkg::*;

   localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int SW  = (COLUMNS > 8) ? $clog2(COLUMNS) : 3;
   localparam int PW  = 15 + $clog2(COLUMNS + 1);
   localparam logic [SW-1:0] LAST_COL  = SW'(COLUMNS - 1);
   localparam logic [SW-1:0] LAST_CHAR = SW'(4);

   logic [7:0] base;
   logic [8:0] addr;
   logic       in_range;
   logic       y_ok;
   logic [7:0] mask;
   logic [SW-1:0] end_step;

   always_comb begin
      unique case (cmd.action)
         ACT_SET_PIXEL, ACT_CLEAR_PIXEL, ACT_READ_PIXEL,
         ACT_SET_COLUMN, ACT_CHAR: base = cmd.x_pos;
         default:                  base = 8'd0;
      endcase
      unique case (cmd.action)
         ACT_CLEAR, ACT_FILL, ACT_BAR: end_step = LAST_COL;
         ACT_CHAR:                     end_step = LAST_CHAR;
         default:                      end_step = '0;
      endcase
   end

   assign addr     = 9'(base) + 9'(step);
   assign in_range = addr < 9'(COLUMNS);
   assign y_ok     = cmd.y_pos[7:3] == 5'd0;
   assign mask     = 8'd1 << cmd.y_pos[2:0];
   assign idx      = in_range ? addr[CIW-1:0] : '0;
   assign acc_next = acc + PW'(cmd.bar_max);

   always_comb begin
      ctl.wr_en     = 1'b0;
      ctl.wr_data   = BYTE_ZEROS;
      ctl.pix       = 1'b0;
      ctl.last_step = step == end_step;
      unique case (cmd.action)
         ACT_SET_PIXEL: begin
            ctl.wr_en   = in_range && y_ok;
            ctl.wr_data = rd_data | mask;
         end
         ACT_CLEAR_PIXEL: begin
            ctl.wr_en   = in_range && y_ok;
            ctl.wr_data = rd_data & ~mask;
         end
         ACT_READ_PIXEL: begin
            ctl.pix = in_range && y_ok && rd_data[cmd.y_pos[2:0]];
         end
         ACT_SET_COLUMN: begin
            ctl.wr_en   = in_range;
            ctl.wr_data = cmd.column_data;
         end
         ACT_CLEAR: begin
            ctl.wr_en = 1'b1;
         end
         ACT_FILL: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_data = BYTE_ONES;
         end
         ACT_BAR: begin
            // column i lit when (i+1)*max <= value*COLUMNS
            ctl.wr_en   = 1'b1;
            ctl.wr_data = (acc <= target) ? BYTE_ONES : BYTE_ZEROS;
         end
         ACT_CHAR: begin
            ctl.wr_en   = in_range;
            ctl.wr_data = font_column(cmd.glyph, step[2:0]);
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/core/led_matrix_framebuffer_engine.sv
// top level of the led matrix framebuffer engine
//  - req_ channel carries one drawing command per item (valid/ready); the
//    block takes a new item only while its sequencer is idle
//  - rsp_ channel returns the result items (valid/ready) through an output
//    register, so an item can be accepted while the previous result waits
//  - pixel set/clear/read and set column: one column step, then the
//    result is registered from the done state
//  - clear, fill and bar: one column written per cycle by the shared
//    column unit
//  - character: five glyph columns, one per step of the column unit
//  - flush: header word then one word per column, last column first,
//    1 + COLUMNS results at one per cycle when the receiver keeps up
//  - bar width is found without a divider: an accumulator adds the full
//    scale once per column and is compared with value * COLUMNS
//  - reset (synchronous, active high) clears the framebuffer to zeros,
//    drops any pending result and returns the sequencer to idle
//  - when the receiver stalls, the sequencer holds at its next emission
//    and the framebuffer is left untouched until the word is taken
module led_matrix_framebuffer_engine #(
   parameter int COLUMNS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic [7:0]  req_column_data,
   input  logic signed [15:0] req_bar_value,
   input  logic [14:0] req_bar_max,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pixel_value,
   output logic [7:0]  rsp_next_x,
   output logic [15:0] rsp_serial_word,
   output logic [4:0]  rsp_serial_bits,
   output logic        rsp_bar_error,
   output logic        rsp_last
);
   import lmfe_pkg::*;

   localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int SW  = (COLUMNS > 8) ? $clog2(COLUMNS) : 3;
   localparam int PW  = 15 + $clog2(COLUMNS + 1);
   localparam logic [SW-1:0]  FLUSH_LAST = SW'(COLUMNS - 1);
   localparam logic [CIW-1:0] TOP_COL    = CIW'(COLUMNS - 1);

   // framebuffer, one byte per column
   logic [7:0] frame_ff [COLUMNS];

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [SW-1:0] step_ff, step_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] target_ff, target_in;
   logic          pix_ff, pix_in;
   logic          err_ff, err_in;

   logic          rsp_valid_ff;
   logic          rsp_pixel_value_ff;
   logic [7:0]    rsp_next_x_ff;
   logic [15:0]   rsp_serial_word_ff;
   logic [4:0]    rsp_serial_bits_ff;
   logic          rsp_bar_error_ff;
   logic          rsp_last_ff;

   logic          accept;
   logic          slot_free;
   logic [14:0]   clamped;
   logic [5:0]    glyph;
   logic [CIW-1:0] unit_idx;
   logic [CIW-1:0] rd_idx;
   logic [7:0]    rd_data;
   logic [PW-1:0] acc_next;
   unit_ctl_type  ctl;
   logic          wr_fire;

   logic          emit;
   logic          e_pix;
   logic [7:0]    e_nx;
   logic [15:0]   e_word;
   logic [4:0]    e_bits;
   logic          e_err;
   logic          e_last;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // value clamped to 0..max
   always_comb begin
      if (req_bar_value[15]) begin
         clamped = 15'd0;
      end else if (req_bar_value[14:0] > req_bar_max) begin
         clamped = req_bar_max;
      end else begin
         clamped = req_bar_value[14:0];
      end
   end

   // codes outside the font draw as a space
   assign glyph = (req_char_code >= FONT_LO && req_char_code <= FONT_HI)
                  ? 6'(req_char_code - FONT_LO) : 6'd0;

   lmfe_col_unit #(
      .COLUMNS (COLUMNS)
   ) u_col_unit (
      .cmd      (cmd_ff),
      .step     (step_ff),
      .rd_data  (rd_data),
      .acc      (acc_ff),
      .target   (target_ff),
      .idx      (unit_idx),
      .acc_next (acc_next),
      .ctl      (ctl)
   );

   // flush walks from the last column down
   assign rd_idx  = (state_ff == ST_FLUSH) ? (TOP_COL - step_ff[CIW-1:0]) : unit_idx;
   assign rd_data = frame_ff[rd_idx];
   assign wr_fire = (state_ff == ST_WALK) && ctl.wr_en;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      target_in = target_ff;
      pix_in    = pix_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      e_pix     = 1'b0;
      e_nx      = 8'd0;
      e_word    = 16'd0;
      e_bits    = 5'd0;
      e_err     = 1'b0;
      e_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in.action      = action_type'(req_action);
               cmd_in.x_pos       = req_x_pos;
               cmd_in.y_pos       = req_y_pos;
               cmd_in.column_data = req_column_data;
               cmd_in.bar_max     = req_bar_max;
               cmd_in.glyph       = glyph;
               step_in   = '0;
               acc_in    = PW'(req_bar_max);
               target_in = PW'(clamped) * PW'(COLUMNS);
               pix_in    = 1'b0;
               err_in    = 1'b0;
               unique case (req_action)
                  ACT_SET_PIXEL, ACT_CLEAR_PIXEL, ACT_READ_PIXEL, ACT_SET_COLUMN,
                  ACT_CLEAR, ACT_FILL, ACT_CHAR: state_in = ST_WALK;
                  ACT_BAR: begin
                     if (req_bar_max == 15'd0) begin
                        err_in   = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  ACT_FLUSH: state_in = ST_HEAD;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            acc_in = acc_next;
            if (cmd_ff.action == ACT_READ_PIXEL) begin
               pix_in = ctl.pix;
            end
            if (ctl.last_step) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_pix    = pix_ff;
               e_nx     = (cmd_ff.action == ACT_CHAR) ? cmd_ff.x_pos + CHAR_ADVANCE : 8'd0;
               e_err    = err_ff;
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HEAD: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_word   = HEADER_WORD;
               e_bits   = HEADER_BITS;
               step_in  = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_word = {rd_data, 8'd0};
               e_bits = COLUMN_BITS;
               e_last = step_ff == FLUSH_LAST;
               if (step_ff == FLUSH_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + SW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      target_ff <= target_in;
      pix_ff    <= pix_in;
      err_ff    <= err_in;
      if (emit) begin
         rsp_pixel_value_ff <= e_pix;
         rsp_next_x_ff      <= e_nx;
         rsp_serial_word_ff <= e_word;
         rsp_serial_bits_ff <= e_bits;
         rsp_bar_error_ff   <= e_err;
         rsp_last_ff        <= e_last;
      end
   end

   // framebuffer has a defined reset value, so every byte is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) begin
            frame_ff[i] <= 8'd0;
         end
      end else if (wr_fire) begin
         frame_ff[unit_idx] <= ctl.wr_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;
   assign rsp_next_x      = rsp_next_x_ff;
   assign rsp_serial_word = rsp_serial_word_ff;
   assign rsp_serial_bits = rsp_serial_bits_ff;
   assign rsp_bar_error   = rsp_bar_error_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### verif/tb_led_matrix_framebuffer_engine.sv
`timescale 1ns / 1ps
// self-checking testbench for the led matrix framebuffer engine
module tb_led_matrix_framebuffer_engine;
   import lmfe_pkg::*;

   localparam int         COLUMNS         = 24;
   localparam logic [3:0] ACT_SPARE_FIRST = 4'd9;
   localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;
   localparam int         MAX_GAP         = 9;
   localparam int         REPORT_LIMIT    = 10;
   localparam int         SETTLE_CYCLES   = 40;
   localparam int         LONG_STALL      = 300;

   // one drawing command as offered on the request side
   typedef struct {
      logic [3:0]         action;
      logic [7:0]         x_pos;
      logic [7:0]         y_pos;
      logic [7:0]         column_data;
      logic signed [15:0] bar_value;
      logic [14:0]        bar_max;
      logic [7:0]         char_code;
   } draw_cmd_type;

   // one result item as seen on the response side
   typedef struct {
      logic        pixel_value;
      logic [7:0]  next_x;
      logic [15:0] serial_word;
      logic [4:0]  serial_bits;
      logic        bar_error;
      logic        last;
   } result_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [3:0]         req_action      = '0;
   logic [7:0]         req_x_pos       = '0;
   logic [7:0]         req_y_pos       = '0;
   logic [7:0]         req_column_data = '0;
   logic signed [15:0] req_bar_value   = '0;
   logic [14:0]        req_bar_max     = '0;
   logic [7:0]         req_char_code   = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic               rsp_pixel_value;
   logic [7:0]         rsp_next_x;
   logic [15:0]        rsp_serial_word;
   logic [4:0]         rsp_serial_bits;
   logic               rsp_bar_error;
   logic               rsp_last;

   // shadow copy of the framebuffer, updated when a command is accepted
   logic [7:0] frame_model [COLUMNS];
   // results still owed by the block, oldest first
   result_type pending_results [$];

   // 5x7 font, leftmost column in the top byte
   logic [39:0] glyph_bits [0:58] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h3E415D551E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543
   };

   // idling controls for the sender and the receiver
   bit send_gaps_on      = 1'b1;
   bit recv_gaps_on      = 1'b1;
   int ready_hold_cycles = 0;
   int next_gap          = 0;
   bit offer_open        = 1'b0;

   // run statistics
   int commands_sent  = 0;
   int flushes_sent   = 0;
   int bars_sent      = 0;
   int glyphs_sent    = 0;
   int results_seen   = 0;
   int mismatch_count = 0;

   led_matrix_framebuffer_engine #(
      .COLUMNS(COLUMNS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_column_data(req_column_data),
      .req_bar_value  (req_bar_value),
      .req_bar_max    (req_bar_max),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_next_x     (rsp_next_x),
      .rsp_serial_word(rsp_serial_word),
      .rsp_serial_bits(rsp_serial_bits),
      .rsp_bar_error  (rsp_bar_error),
      .rsp_last       (rsp_last)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic result_type make_result(input logic pix, input logic [7:0] nx,
                                              input logic [15:0] word, input logic [4:0] bits,
                                              input logic err, input logic fin);
      result_type r;
      r.pixel_value = pix;
      r.next_x      = nx;
      r.serial_word = word;
      r.serial_bits = bits;
      r.bar_error   = err;
      r.last        = fin;
      return r;
   endfunction

   function automatic draw_cmd_type mk_cmd(input logic [3:0] action, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] data,
                                           input logic signed [15:0] value,
                                           input logic [14:0] full_scale,
                                           input logic [7:0] code);
      draw_cmd_type c;
      c.action      = action;
      c.x_pos       = x;
      c.y_pos       = y;
      c.column_data = data;
      c.bar_value   = value;
      c.bar_max     = full_scale;
      c.char_code   = code;
      return c;
   endfunction

   // apply one accepted command to the shadow framebuffer and queue its results
   task automatic predict_results(input draw_cmd_type c);
      bit         on_grid;
      logic       pix;
      logic       err;
      logic [7:0] nx;
      int         level;
      int         bar_width;
      int         glyph;
      int         col;
      on_grid = (c.x_pos < COLUMNS) && (c.y_pos < 8);
      pix     = 1'b0;
      err     = 1'b0;
      nx      = 8'd0;
      case (c.action)
         ACT_SET_PIXEL: begin
            if (on_grid) frame_model[c.x_pos][c.y_pos[2:0]] = 1'b1;
         end
         ACT_CLEAR_PIXEL: begin
            if (on_grid) frame_model[c.x_pos][c.y_pos[2:0]] = 1'b0;
         end
         ACT_READ_PIXEL: begin
            if (on_grid) pix = frame_model[c.x_pos][c.y_pos[2:0]];
         end
         ACT_SET_COLUMN: begin
            if (c.x_pos < COLUMNS) frame_model[c.x_pos] = c.column_data;
         end
         ACT_CLEAR: begin
            foreach (frame_model[i]) frame_model[i] = BYTE_ZEROS;
         end
         ACT_FILL: begin
            foreach (frame_model[i]) frame_model[i] = BYTE_ONES;
         end
         ACT_BAR: begin
            bars_sent++;
            if (c.bar_max == 15'd0) begin
               // zero full scale: flag it, buffer untouched
               err = 1'b1;
            end else begin
               level = int'(c.bar_value);
               if (level < 0) level = 0;
               if (level > int'(c.bar_max)) level = int'(c.bar_max);
               bar_width = (level * COLUMNS) / int'(c.bar_max);
               foreach (frame_model[i])
                  frame_model[i] = (i < bar_width) ? BYTE_ONES : BYTE_ZEROS;
            end
         end
         ACT_CHAR: begin
            glyphs_sent++;
            // codes outside the font draw as a space
            glyph = (c.char_code >= FONT_LO && c.char_code <= FONT_HI) ?
                    int'(c.char_code - FONT_LO) : 0;
            for (int i = 0; i < 5; i++) begin
               col = int'(c.x_pos) + i;
               // columns past the right edge are dropped
               if (col < COLUMNS) frame_model[col] = glyph_bits[glyph][39 - 8 * i -: 8];
            end
            nx = c.x_pos + CHAR_ADVANCE;
         end
         ACT_FLUSH: begin
            flushes_sent++;
            pending_results.push_back(make_result(1'b0, 8'd0, HEADER_WORD, HEADER_BITS,
                                                  1'b0, 1'b0));
            for (int i = COLUMNS - 1; i >= 0; i--)
               pending_results.push_back(make_result(1'b0, 8'd0, {frame_model[i], 8'h00},
                                                     COLUMN_BITS, 1'b0, i == 0));
         end
         default: ; // spare codes leave the buffer alone
      endcase
      if (c.action != ACT_FLUSH)
         pending_results.push_back(make_result(pix, nx, 16'h0000, 5'd0, err, 1'b1));
   endtask

   // offer one command, hold it until taken, then predict its results
   task automatic issue(input draw_cmd_type c);
      if (next_gap > 0) repeat (next_gap) @(posedge clock);
      req_action      <= c.action;
      req_x_pos       <= c.x_pos;
      req_y_pos       <= c.y_pos;
      req_column_data <= c.column_data;
      req_bar_value   <= c.bar_value;
      req_bar_max     <= c.bar_max;
      req_char_code   <= c.char_code;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      commands_sent++;
      predict_results(c);
      // decide now whether valid drops, so it is never lowered and raised in one step
      next_gap = send_gaps_on ? int'($urandom_range(0, MAX_GAP)) : 0;
      if (next_gap > 0) begin
         req_valid  <= 1'b0;
         offer_open  = 1'b0;
      end else begin
         offer_open  = 1'b1;
      end
   endtask

   task automatic stop_offering();
      if (offer_open) begin
         req_valid  <= 1'b0;
         offer_open  = 1'b0;
      end
   endtask

   // sender goes quiet until every owed result has come back
   task automatic wait_for_drain();
      stop_offering();
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // random command: mostly on-grid coordinates, all fields exercised
   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int           pick;
      c.action      = ACT_FLUSH;
      c.x_pos       = 8'($urandom);
      c.y_pos       = 8'($urandom);
      c.column_data = 8'($urandom);
      c.bar_value   = 16'($urandom);
      c.bar_max     = 15'($urandom);
      c.char_code   = 8'($urandom);
      if ($urandom_range(0, 3) != 0) c.x_pos = 8'($urandom_range(0, COLUMNS));
      if ($urandom_range(0, 3) != 0) c.y_pos = 8'($urandom_range(0, 8));
      pick = int'($urandom_range(0, 99));
      if (pick < 14)      c.action = ACT_SET_PIXEL;
      else if (pick < 22) c.action = ACT_CLEAR_PIXEL;
      else if (pick < 34) c.action = ACT_READ_PIXEL;
      else if (pick < 47) c.action = ACT_SET_COLUMN;
      else if (pick < 50) c.action = ACT_CLEAR;
      else if (pick < 53) c.action = ACT_FILL;
      else if (pick < 66) c.action = ACT_BAR;
      else if (pick < 80) c.action = ACT_CHAR;
      else if (pick < 93) c.action = ACT_FLUSH;
      else c.action = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      if (c.action == ACT_BAR) begin
         pick = int'($urandom_range(0, 7));
         if (pick == 0) begin
            c.bar_max = 15'd0;
         end else if (pick < 5) begin
            // small scales give every bar width a fair chance
            c.bar_max   = 15'($urandom_range(1, 48));
            c.bar_value = 16'(int'($urandom_range(0, 64)) - 4);
         end
      end
      if (c.action == ACT_CHAR && $urandom_range(0, 1) == 1)
         c.char_code = 8'($urandom_range(FONT_LO, FONT_HI));
      return c;
   endfunction

   // ---------------------------------------------------------------- tests

   // pixel set, clear and read, corners and off-grid coordinates
   task automatic test_pixel_ops();
      issue(mk_cmd(ACT_SET_PIXEL,   8'd0,   8'd0,   8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_SET_PIXEL,   8'd23,  8'd7,   8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_SET_PIXEL,   8'd24,  8'd3,   8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_SET_PIXEL,   8'd5,   8'd8,   8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_READ_PIXEL,  8'd23,  8'd7,   8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_READ_PIXEL,  8'd255, 8'd255, 8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_CLEAR_PIXEL, 8'd23,  8'd7,   8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_READ_PIXEL,  8'd23,  8'd7,   8'h00, 16'sd0, 15'd0, 8'd0));
   endtask

   // column writes, including ones past the right edge
   task automatic test_column_writes();
      issue(mk_cmd(ACT_SET_COLUMN, 8'd0,   8'd0, 8'hA5, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_SET_COLUMN, 8'd24,  8'd0, 8'hFF, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_SET_COLUMN, 8'd255, 8'd0, 8'h5A, 16'sd0, 15'd0, 8'd0));
   endtask

   // fill then clear of the whole buffer, with a read and a flush in between
   task automatic test_bulk_fill();
      issue(mk_cmd(ACT_FILL,       8'd0, 8'd0, 8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_READ_PIXEL, 8'd3, 8'd3, 8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_FLUSH,      8'd0, 8'd0, 8'h00, 16'sd0, 15'd0, 8'd0));
      issue(mk_cmd(ACT_CLEAR,      8'd0, 8'd0, 8'h00, 16'sd0, 15'd0, 8'd0));
   endtask

   // bar graph: zero scale error, clamping both ways, a partial width, then a flush
   task automatic test_bar_graph();
      issue(mk_cmd(ACT_BAR, 8'd0, 8'd0, 8'h00, 16'sd5,      15'd0,     8'd0));
      issue(mk_cmd(ACT_BAR, 8'd0, 8'd0, 8'h00, 16'sh8000,   15'd32767, 8'd0));
      issue(mk_cmd(ACT_BAR, 8'd0, 8'd0, 8'h00, 16'sd32767,  15'd100,   8'd0));
      issue(mk_cmd(ACT_BAR, 8'd0, 8'd0, 8'h00, 16'sd1,      15'd3,     8'd0));
      issue(mk_cmd(ACT_FLUSH, 8'd0, 8'd0, 8'h00, 16'sd0,    15'd0,     8'd0));
   endtask

   // glyphs: in font, out of font, clipped at the edge, advance wrap
   task automatic test_glyphs();
      issue(mk_cmd(ACT_CHAR,  8'd0,   8'd0, 8'h00, 16'sd0, 15'd0, 8'd65));
      issue(mk_cmd(ACT_CHAR,  8'd20,  8'd0, 8'h00, 16'sd0, 15'd0, 8'd90));
      issue(mk_cmd(ACT_CHAR,  8'd8,   8'd0, 8'h00, 16'sd0, 15'd0, 8'd31));
      issue(mk_cmd(ACT_CHAR,  8'd250, 8'd0, 8'h00, 16'sd0, 15'd0, 8'd200));
      issue(mk_cmd(ACT_FLUSH, 8'd0,   8'd0, 8'h00, 16'sd0, 15'd0, 8'd0));
   endtask

   // unused action codes give one empty result
   task automatic test_spare_actions();
      issue(mk_cmd(ACT_SPARE_FIRST, 8'd1, 8'd1, 8'hFF, 16'sd7, 15'd7, 8'd65));
      issue(mk_cmd(ACT_SPARE_LAST,  8'd2, 8'd2, 8'hFF, 16'sd7, 15'd7, 8'd66));
   endtask

   // receiver holds off while flushes keep coming, so the request side stalls
   task automatic test_output_stall();
      wait_for_drain();
      send_gaps_on      = 1'b0;
      ready_hold_cycles = LONG_STALL;
      repeat (4) issue(mk_cmd(ACT_FLUSH, 8'd0, 8'd0, 8'h00, 16'sd0, 15'd0, 8'd0));
      repeat (4) issue(random_cmd());
      wait_for_drain();
      send_gaps_on = 1'b1;
   endtask

   // back to back on both sides, no idling at all
   task automatic test_streaming();
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      repeat (60) issue(random_cmd());
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
   endtask

   // long random mix with an occasional full drain
   task automatic test_random_mix();
      for (int n = 0; n < 320; n++) begin
         issue(random_cmd());
         if (n % 80 == 79) wait_for_drain();
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic log_mismatch(input string what, input result_type want,
                               input result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch at %0t (%s)", $realtime, what);
         $display("  expected pix=%0b nx=%0d word=%h bits=%0d err=%0b last=%0b",
                  want.pixel_value, want.next_x, want.serial_word, want.serial_bits,
                  want.bar_error, want.last);
         $display("  actual   pix=%0b nx=%0d word=%h bits=%0d err=%0b last=%0b",
                  got.pixel_value, got.next_x, got.serial_word, got.serial_bits,
                  got.bar_error, got.last);
      end
   endtask

   // compare every accepted result item against the oldest one owed
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = make_result(rsp_pixel_value, rsp_next_x, rsp_serial_word, rsp_serial_bits,
                           rsp_bar_error, rsp_last);
         results_seen++;
         if (pending_results.size() == 0) begin
            want = make_result(1'b0, 8'd0, 16'h0000, 5'd0, 1'b0, 1'b0);
            log_mismatch("result with nothing owed", want, got);
         end else begin
            want = pending_results.pop_front();
            if (got.pixel_value !== want.pixel_value || got.next_x !== want.next_x ||
                got.serial_word !== want.serial_word || got.serial_bits !== want.serial_bits ||
                got.bar_error !== want.bar_error || got.last !== want.last)
               log_mismatch("field differs", want, got);
         end
      end
   end

   // result receiver: random stalls, plus a long hold-off when a test asks for one
   initial begin : take_results
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (ready_hold_cycles > 0) begin
            wait_cycles       = ready_hold_cycles;
            ready_hold_cycles = 0;
         end else begin
            wait_cycles = recv_gaps_on ? int'($urandom_range(0, MAX_GAP)) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // give up if the run hangs
   initial begin : watchdog
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : run_tests
      foreach (frame_model[i]) frame_model[i] = BYTE_ZEROS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_pixel_ops();
      test_column_writes();
      test_bulk_fill();
      test_bar_graph();
      test_glyphs();
      test_spare_actions();
      test_output_stall();
      test_streaming();
      test_random_mix();

      // let the last results come home, then a little extra for stragglers
      stop_offering();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("drove %0d commands: %0d flushes, %0d bar graphs, %0d glyphs",
               commands_sent, flushes_sent, bars_sent, glyphs_sent);
      $display("checked %0d result items, %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### led_matrix_framebuffer_engine.f
rtl/core/lmfe_pkg.sv
rtl/core/lmfe_col_unit.sv
rtl/core/led_matrix_framebuffer_engine.sv
verif/tb_led_matrix_framebuffer_engine.sv
